/* rtl/tcbcw_pkg.sv */
package tcbcw_pkg;

   // request function codes
   localparam logic [2:0] FN_PUT     = 3'd0;
   localparam logic [2:0] FN_MOVE    = 3'd1;
   localparam logic [2:0] FN_CLR_ROW = 3'd2;
   localparam logic [2:0] FN_CLR_ALL = 3'd3;
   localparam logic [2:0] FN_READ    = 3'd4;

   // character codes with a meaning of their own
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // relative move directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // tab stops every 4 columns
   localparam int TAB_SHIFT = 2;
   localparam int TAB_STEP  = 1 << TAB_SHIFT;

   typedef enum logic [1:0] {
      ST_OK,
      ST_MOVE_RANGE,
      ST_OVERFLOW,
      ST_UNSUPPORTED
   } status_type;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LF,
      UOP_CR,
      UOP_TAB,
      UOP_BS,
      UOP_UNSUP,
      UOP_MOVE,
      UOP_CLR_ROW,
      UOP_CLR_ALL,
      UOP_READ,
      UOP_STORE,
      UOP_PAD,
      UOP_FIN
   } uop_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_NEED_PAD,
      COND_PAD_MORE
   } cond_type;

   typedef logic [3:0] upc_type;

   // microprogram addresses
   localparam upc_type UA_IDLE    = 4'd0;
   localparam upc_type UA_NOP     = 4'd1;
   localparam upc_type UA_LF      = 4'd2;
   localparam upc_type UA_CR      = 4'd3;
   localparam upc_type UA_TAB     = 4'd4;
   localparam upc_type UA_BS      = 4'd5;
   localparam upc_type UA_UNSUP   = 4'd6;
   localparam upc_type UA_MOVE    = 4'd7;
   localparam upc_type UA_CLR_ROW = 4'd8;
   localparam upc_type UA_CLR_ALL = 4'd9;
   localparam upc_type UA_READ    = 4'd10;
   localparam upc_type UA_STORE   = 4'd11;
   localparam upc_type UA_PAD     = 4'd12;
   localparam upc_type UA_FIN     = 4'd13;

   // one control word: datapath op, jump condition and target, dispatch, end of item
   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      upc_type  target;
      logic     dispatch;
      logic     done;
   } cw_type;

   typedef struct packed {
      uop_type uop;
      logic    en;
      logic    accept;
      logic    finish;
      logic    idle;
   } ctrl_type;

   typedef struct packed {
      logic need_pad;
      logic pad_more;
   } flags_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  cell_char;
      logic [7:0]  row_length;
      logic [7:0]  cursor_x;
      logic [5:0]  cursor_y;
      logic [5:0]  rows_used;
   } rsp_type;

   // next = hold ? current : jump ? target : dispatch ? decoded entry : done ? idle : next address
   function automatic cw_type ucode_rom(upc_type a);
      cw_type w;
      w.uop      = UOP_NONE;
      w.cond     = COND_NEVER;
      w.target   = UA_IDLE;
      w.dispatch = 1'b0;
      w.done     = 1'b1;
      unique case (a)
         UA_IDLE: begin
            w.cond     = COND_NO_REQ;
            w.dispatch = 1'b1;
            w.done     = 1'b0;
         end
         UA_NOP:     w.uop = UOP_NONE;
         UA_LF:      w.uop = UOP_LF;
         UA_CR:      w.uop = UOP_CR;
         UA_TAB:     w.uop = UOP_TAB;
         UA_BS:      w.uop = UOP_BS;
         UA_UNSUP:   w.uop = UOP_UNSUP;
         UA_MOVE:    w.uop = UOP_MOVE;
         UA_CLR_ROW: w.uop = UOP_CLR_ROW;
         UA_CLR_ALL: w.uop = UOP_CLR_ALL;
         UA_READ:    w.uop = UOP_READ;
         UA_STORE: begin
            w.uop    = UOP_STORE;
            w.cond   = COND_NEED_PAD;
            w.target = UA_PAD;
         end
         UA_PAD: begin
            w.uop    = UOP_PAD;
            w.cond   = COND_PAD_MORE;
            w.target = UA_PAD;
            w.done   = 1'b0;
         end
         UA_FIN:     w.uop = UOP_FIN;
         default: begin
            w.cond     = COND_NO_REQ;
            w.dispatch = 1'b1;
            w.done     = 1'b0;
         end
      endcase
      return w;
   endfunction

   function automatic upc_type dispatch_addr(logic [2:0] f, logic [7:0] ch);
      upc_type a;
      a = UA_NOP;
      case (f)
         FN_PUT: begin
            case (ch) inside
               CH_NUL:                a = UA_NOP;
               CH_LF:                 a = UA_LF;
               CH_CR:                 a = UA_CR;
               CH_TAB:                a = UA_TAB;
               CH_BS:                 a = UA_BS;
               CH_BEL, CH_VT, CH_FF:  a = UA_UNSUP;
               default:               a = UA_STORE;
            endcase
         end
         FN_MOVE:    a = UA_MOVE;
         FN_CLR_ROW: a = UA_CLR_ROW;
         FN_CLR_ALL: a = UA_CLR_ALL;
         FN_READ:    a = UA_READ;
         default:    a = UA_NOP;
      endcase
      return a;
   endfunction

endpackage

/* rtl/tcbcw_seq.sv */
module tcbcw_seq
   import tcbcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_func,
   input  logic [7:0] req_char_code,
   input  flags_type  flags,
   input  logic       out_busy,
   output ctrl_type   ctrl
);

   upc_type upc_ff;
   upc_type upc_in;
   cw_type  cw;
   logic    jump;
   logic    finishing;
   logic    hold;

   always_comb begin
      cw = ucode_rom(upc_ff);
      case (cw.cond)
         COND_NO_REQ:   jump = !req_valid;
         COND_NEED_PAD: jump = flags.need_pad;
         COND_PAD_MORE: jump = flags.pad_more;
         default:       jump = 1'b0;
      endcase
      finishing = cw.done && !jump;
      // last step waits while the result register is still occupied
      hold = finishing && out_busy;

      if (hold) begin
         upc_in = upc_ff;
      end else if (jump) begin
         upc_in = cw.target;
      end else if (cw.dispatch) begin
         upc_in = dispatch_addr(req_func, req_char_code);
      end else if (cw.done) begin
         upc_in = UA_IDLE;
      end else begin
         upc_in = upc_ff + 1'b1;
      end

      ctrl.uop    = cw.uop;
      ctrl.en     = !hold;
      ctrl.idle   = (upc_ff == UA_IDLE);
      ctrl.accept = (upc_ff == UA_IDLE) && req_valid;
      ctrl.finish = finishing && !hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> !ctrl.idle)
      else $error("sequencer stayed idle after a transfer");

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> ctrl.idle)
      else $error("sequencer did not return to idle after finishing");

endmodule

/* rtl/tcbcw_dp.sv */
module tcbcw_dp
   import tcbcw_pkg::*;
#(
   parameter int SCREEN_COLS = 128,
   parameter int SCREEN_ROWS = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   input  logic [2:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [1:0] req_move_direction,
   input  logic [7:0] req_move_amount,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output flags_type  flags,
   output rsp_type    rsp_next
);

   localparam int CW       = $clog2(SCREEN_COLS);
   localparam int RW       = $clog2(SCREEN_ROWS);
   localparam int XW       = $clog2(SCREEN_COLS + 1);
   localparam int YW       = $clog2(SCREEN_ROWS + 1);
   localparam int MW       = ((XW > 8) ? XW : 8) + 1;
   localparam int CS_DEPTH = 1 << (RW + CW);

   // cursor and usage state
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [YW-1:0] used_ff, used_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [SCREEN_ROWS-1:0] len_vld_ff;

   // stores
   logic [XW-1:0] len_mem_ff [SCREEN_ROWS];
   logic [7:0]    cell_mem_ff [CS_DEPTH];

   // captured request and read data
   logic [7:0]    ch_ff;
   logic [1:0]    dir_ff;
   logic [7:0]    amt_ff;
   logic [6:0]    rc_ff;
   logic          rr_ok_ff;
   logic [XW-1:0] len_q_ff;
   logic          len_qv_ff;
   logic [7:0]    cell_q_ff;

   logic [RW-1:0] row_idx;
   logic [RW-1:0] rd_idx;
   logic [XW-1:0] len_cur;
   logic [XW-1:0] col_inc;
   logic          overflow;
   logic [XW:0]   tab_tgt;
   logic [MW-1:0] amt_w, col_w, row_w;
   logic          do_store;
   logic          cs_we;
   logic [CW-1:0] cs_wcol;
   logic [7:0]    cs_wdata;
   logic          len_we;
   logic          len_clr;
   logic          clr_all;
   status_type    status;
   logic [7:0]    rd_char;
   logic [XW-1:0] rlen;

   assign row_idx = row_ff[RW-1:0];
   assign rd_idx  = (req_func == FN_READ) ? RW'(req_read_row) : row_idx;
   assign len_cur = len_qv_ff ? len_q_ff : '0;
   assign col_inc = col_ff + 1'b1;
   assign overflow = (col_ff >= XW'(SCREEN_COLS)) || (row_ff >= YW'(SCREEN_ROWS));

   assign flags.need_pad = !overflow && (len_cur < col_ff);
   assign flags.pad_more = ((XW+1)'(ptr_ff) + (XW+1)'(1)) < (XW+1)'(col_ff);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      used_in  = used_ff;
      ptr_in   = ptr_ff;
      status   = ST_OK;
      rd_char  = '0;
      rlen     = '0;
      do_store = 1'b0;
      cs_we    = 1'b0;
      cs_wcol  = col_ff[CW-1:0];
      cs_wdata = ch_ff;
      len_we   = 1'b0;
      len_clr  = 1'b0;
      clr_all  = 1'b0;
      amt_w    = MW'(amt_ff);
      col_w    = MW'(col_ff);
      row_w    = MW'(row_ff);
      tab_tgt  = {1'b0, col_ff[XW-1:TAB_SHIFT], {TAB_SHIFT{1'b0}}} + (XW+1)'(TAB_STEP);

      unique case (ctrl.uop)
         UOP_LF: begin
            if ((YW+1)'(row_ff) + (YW+1)'(1) <= (YW+1)'(SCREEN_ROWS)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               status = ST_MOVE_RANGE;
            end
         end
         UOP_CR: col_in = '0;
         UOP_TAB: begin
            if (tab_tgt <= (XW+1)'(SCREEN_COLS)) begin
               col_in = XW'(tab_tgt);
            end else begin
               status = ST_MOVE_RANGE;
            end
         end
         UOP_BS: begin
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
            end
         end
         UOP_UNSUP: status = ST_UNSUPPORTED;
         UOP_MOVE: begin
            case (dir_ff)
               DIR_UP: begin
                  if (amt_w > row_w) status = ST_MOVE_RANGE;
                  else row_in = YW'(row_w - amt_w);
               end
               DIR_DOWN: begin
                  if (row_w + amt_w >= MW'(SCREEN_ROWS)) status = ST_MOVE_RANGE;
                  else row_in = YW'(row_w + amt_w);
               end
               DIR_LEFT: begin
                  if (amt_w > col_w) status = ST_MOVE_RANGE;
                  else col_in = XW'(col_w - amt_w);
               end
               default: begin
                  if (col_w + amt_w >= MW'(SCREEN_COLS)) status = ST_MOVE_RANGE;
                  else col_in = XW'(col_w + amt_w);
               end
            endcase
         end
         UOP_CLR_ROW: len_clr = (row_ff < YW'(SCREEN_ROWS));
         UOP_CLR_ALL: begin
            clr_all = 1'b1;
            col_in  = '0;
            row_in  = '0;
            used_in = '0;
         end
         UOP_READ: begin
            if (rr_ok_ff) begin
               rlen = len_cur;
               if ((XW+8)'(rc_ff) < (XW+8)'(len_cur)) begin
                  rd_char = cell_q_ff;
               end
            end
         end
         UOP_STORE: begin
            // a gap between the row end and the cursor is filled first
            if (flags.need_pad) begin
               ptr_in = CW'(len_cur);
            end else begin
               do_store = 1'b1;
            end
         end
         UOP_PAD: begin
            cs_we    = 1'b1;
            cs_wcol  = ptr_ff;
            cs_wdata = CH_SPACE;
            ptr_in   = ptr_ff + 1'b1;
         end
         UOP_FIN: do_store = 1'b1;
         default: ;
      endcase

      if (do_store) begin
         if (overflow) begin
            status = ST_OVERFLOW;
         end else begin
            cs_we  = 1'b1;
            col_in = col_inc;
            len_we = (col_inc > len_cur);
            if ((YW+1)'(row_ff) + (YW+1)'(1) > (YW+1)'(used_ff)) begin
               used_in = row_ff + 1'b1;
            end
         end
      end

      rsp_next.status     = status;
      rsp_next.cell_char  = rd_char;
      rsp_next.row_length = 8'(rlen);
      rsp_next.cursor_x   = 8'(col_in);
      rsp_next.cursor_y   = 6'(row_in);
      rsp_next.rows_used  = 6'(used_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         used_ff    <= '0;
         len_vld_ff <= '0;
      end else if (ctrl.en) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         used_ff <= used_in;
         if (clr_all) begin
            len_vld_ff <= '0;
         end else if (len_clr) begin
            len_vld_ff[row_idx] <= 1'b0;
         end else if (len_we) begin
            len_vld_ff[row_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         ch_ff     <= req_char_code;
         dir_ff    <= req_move_direction;
         amt_ff    <= req_move_amount;
         rc_ff     <= req_read_col;
         rr_ok_ff  <= (int'(req_read_row) < SCREEN_ROWS);
         len_q_ff  <= len_mem_ff[rd_idx];
         len_qv_ff <= len_vld_ff[rd_idx];
         cell_q_ff <= cell_mem_ff[{RW'(req_read_row), CW'(req_read_col)}];
      end
      if (ctrl.en) begin
         ptr_ff <= ptr_in;
         if (cs_we) begin
            cell_mem_ff[{row_idx, cs_wcol}] <= cs_wdata;
         end
         if (len_we) begin
            len_mem_ff[row_idx] <= col_inc;
         end
      end
   end

   a_pad_below_cursor: assert property (@(posedge clock) disable iff (reset)
      (ctrl.en && (ctrl.uop == UOP_PAD)) |-> ((XW+1)'(ptr_ff) < (XW+1)'(col_ff)))
      else $error("space fill reached the cursor column");

   a_store_advances: assert property (@(posedge clock) disable iff (reset)
      (ctrl.finish && (ctrl.uop == UOP_FIN)) |=> (col_ff != '0))
      else $error("cursor did not advance after a stored character");

   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (ctrl.en && (ctrl.uop == UOP_CLR_ALL)) |=> ((len_vld_ff == '0) && (used_ff == '0)))
      else $error("clear all left row state behind");

endmodule

/* rtl/text_cell_buffer_cursor_writer_top.sv */
// result: registered when the last microcode step of an item finishes; a printable character
// whose row must be space filled up to the cursor runs a store step, fill steps and a final step
// a new request is taken only once the sequencer is back in idle, so items do not overlap; the
// fill writes one space per microcode step through the single write port of the cell memory
// reset: cursor, rows used, sequencer and row lengths clear at once; cell memory is not cleared
module text_cell_buffer_cursor_writer_top
   import tcbcw_pkg::*;
#(
   parameter int SCREEN_COLS = 128,
   parameter int SCREEN_ROWS = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [1:0] req_move_direction,
   input  logic [7:0] req_move_amount,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_row_length,
   output logic [7:0] rsp_cursor_x,
   output logic [5:0] rsp_cursor_y,
   output logic [5:0] rsp_rows_used
);

   ctrl_type  ctrl;
   flags_type flags;
   rsp_type   rsp_next;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      out_busy;

   assign out_busy = rsp_valid_ff && rsp_stall;

   tcbcw_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .flags         (flags),
      .out_busy      (out_busy),
      .ctrl          (ctrl)
   );

   tcbcw_dp #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .req_func           (req_func),
      .req_char_code      (req_char_code),
      .req_move_direction (req_move_direction),
      .req_move_amount    (req_move_amount),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .flags              (flags),
      .rsp_next           (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_ff <= rsp_next;
      end
   end

   assign req_stall      = !ctrl.idle;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_cell_char  = rsp_ff.cell_char;
   assign rsp_row_length = rsp_ff.row_length;
   assign rsp_cursor_x   = rsp_ff.cursor_x;
   assign rsp_cursor_y   = rsp_ff.cursor_y;
   assign rsp_rows_used  = rsp_ff.rows_used;

   a_result_held_until_transfer: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid) && !$past(reset)) |-> !$past(rsp_stall))
      else $error("result dropped without a transfer");

endmodule
